// ===== hw/rtl/fdtp_pkg.sv =====
// fdtp_pkg: types and constants shared by the structure token parser
// no dependencies

package fdtp_pkg;

  typedef enum logic [2:0] {
    PH_TOKEN = 3'd0,
    PH_NAME  = 3'd1,
    PH_PLEN  = 3'd2,
    PH_PNAME = 3'd3,
    PH_SKIP  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    EV_BEGIN   = 3'd0,
    EV_ENDNODE = 3'd1,
    EV_PROP    = 3'd2,
    EV_NOP     = 3'd3,
    EV_END     = 3'd4,
    EV_BAD     = 3'd5
  } evt_kind_e;

  // ref_val carries the name reference, or the token word for a bad token
  typedef struct packed {
    evt_kind_e   kind;
    logic [31:0] ref_val;
    logic [31:0] doff;
    logic [31:0] dlen;
  } evt_t;

  localparam logic [31:0] TokBeginNode = 32'd1;
  localparam logic [31:0] TokEndNode   = 32'd2;
  localparam logic [31:0] TokProp      = 32'd3;
  localparam logic [31:0] TokNop       = 32'd4;
  localparam logic [31:0] TokEnd       = 32'd9;

  localparam logic [31:0] PosLimit     = 32'hFFFF_FFFB;
  localparam logic [31:0] WordBytes    = 32'd4;

endpackage

// ===== hw/rtl/fdtp_front.sv =====
// fdtp_front: accepts structure words, tracks position and parse phase, classifies tokens
// depends on fdtp_pkg

module fdtp_front import fdtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [31:0] word_i,
  input  logic        first_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        evt_valid_o,
  output evt_t        evt_o
);

  phase_e      phase_q, phase_d, phase_eff;
  logic [31:0] pos_q, pos_d, pos_eff, pos_next;
  logic [29:0] skip_q, skip_d, skip_eff, skip_new, skip_dec;
  logic [31:0] held_q, held_d, held_eff, held_plus3;
  logic        halted_q, halted_d, halted_eff;
  logic [31:0] size_q;
  logic        has_zero;

  assign phase_eff  = first_i ? PH_TOKEN : phase_q;
  assign pos_eff    = first_i ? 32'd0 : pos_q;
  assign skip_eff   = first_i ? 30'd0 : skip_q;
  assign held_eff   = first_i ? 32'd0 : held_q;
  assign halted_eff = first_i ? 1'b0 : halted_q;

  assign pos_next   = (pos_eff > PosLimit) ? 32'hFFFF_FFFF : pos_eff + WordBytes;
  assign held_plus3 = held_eff + 32'd3;
  assign skip_new   = held_plus3[31:2];
  assign skip_dec   = skip_eff - 30'd1;
  assign has_zero   = (word_i[31:24] == 8'd0) || (word_i[23:16] == 8'd0) ||
                      (word_i[15:8] == 8'd0) || (word_i[7:0] == 8'd0);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    skip_d      = skip_q;
    held_d      = held_q;
    halted_d    = halted_q;
    evt_valid_o = 1'b0;
    evt_o       = '{kind: EV_NOP, ref_val: 32'd0, doff: 32'd0, dlen: 32'd0};
    if (accept_i) begin
      phase_d  = phase_eff;
      pos_d    = pos_eff;
      skip_d   = skip_eff;
      held_d   = held_eff;
      halted_d = halted_eff;
      if (!halted_eff && (pos_eff < size_q)) begin
        pos_d = pos_next;
        unique case (phase_eff)
          PH_NAME: begin
            if (has_zero) begin
              phase_d = PH_TOKEN;
            end
          end
          PH_PLEN: begin
            held_d  = word_i;
            phase_d = PH_PNAME;
          end
          PH_PNAME: begin
            evt_valid_o = 1'b1;
            evt_o = '{kind: EV_PROP, ref_val: word_i, doff: pos_next, dlen: held_eff};
            skip_d  = skip_new;
            phase_d = (skip_new == 30'd0) ? PH_TOKEN : PH_SKIP;
          end
          PH_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == 30'd0) begin
              phase_d = PH_TOKEN;
            end
          end
          default: begin
            phase_d     = PH_TOKEN;
            evt_valid_o = 1'b1;
            priority if (word_i == TokBeginNode) begin
              evt_o.kind    = EV_BEGIN;
              evt_o.ref_val = pos_next;
              phase_d       = PH_NAME;
            end else if (word_i == TokEndNode) begin
              evt_o.kind = EV_ENDNODE;
            end else if (word_i == TokProp) begin
              evt_valid_o = 1'b0;
              phase_d     = PH_PLEN;
            end else if (word_i == TokNop) begin
              evt_o.kind = EV_NOP;
            end else if (word_i == TokEnd) begin
              evt_o.kind = EV_END;
            end else begin
              evt_o.kind    = EV_BAD;
              evt_o.ref_val = word_i;
              halted_d      = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TOKEN;
      pos_q    <= 32'd0;
      skip_q   <= 30'd0;
      held_q   <= 32'd0;
      halted_q <= 1'b0;
      size_q   <= 32'd0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      skip_q   <= skip_d;
      held_q   <= held_d;
      halted_q <= halted_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && !first_i |-> !evt_valid_o)
    else $error("event while halted");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> skip_q != 30'd0)
    else $error("skip phase with zero count");

  a_first_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && first_i && size_q == 32'd0 |=> pos_q == 32'd0 && !halted_q)
    else $error("restart did not clear state");

endmodule

// ===== hw/rtl/fdtp_queue.sv =====
// fdtp_queue: short event queue between the front and back parts
// depends on fdtp_pkg

module fdtp_queue import fdtp_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  evt_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output logic valid_o,
  output evt_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  evt_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            wr_en, rd_en;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign wr_en     = wr_i && !full_o;
  assign rd_en     = rd_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && !rd_en |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count lost a write");

  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en && !wr_en |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("queue count lost a read");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

// ===== hw/rtl/fdtp_back.sv =====
// fdtp_back: takes events from the queue and drives the registered result ports
// depends on fdtp_pkg

module fdtp_back import fdtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  evt_t        q_data_i,
  output logic        q_rd_o,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_kind_o,
  output logic [31:0] name_ref_o,
  output logic [31:0] data_offset_o,
  output logic [31:0] data_length_o,
  output logic [31:0] bad_token_o
);

  logic        valid_q;
  logic [2:0]  kind_q;
  logic [31:0] name_q, doff_q, dlen_q, bad_q;
  logic        load;
  logic        is_bad;

  assign load   = q_valid_i && (!valid_q || pop);
  assign q_rd_o = load;
  assign is_bad = (q_data_i.kind == EV_BAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (pop) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= q_data_i.kind;
      name_q <= is_bad ? 32'd0 : q_data_i.ref_val;
      bad_q  <= is_bad ? q_data_i.ref_val : 32'd0;
      doff_q <= q_data_i.doff;
      dlen_q <= q_data_i.dlen;
    end
  end

  assign empty         = !valid_q;
  assign event_kind_o  = kind_q;
  assign name_ref_o    = name_q;
  assign data_offset_o = doff_q;
  assign data_length_o = dlen_q;
  assign bad_token_o   = bad_q;

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i && !valid_q |=> valid_q)
    else $error("output stage not filled from queue");

  a_bad_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && kind_q != EV_BAD |-> bad_q == 32'd0)
    else $error("bad token field set on a good event");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && pop && !q_valid_i |=> !valid_q)
    else $error("popped request not retired");

endmodule

// ===== hw/rtl/fdt_structure_token_parser_unit.sv =====
// fdt_structure_token_parser_unit: top level of the structure block token parser
// depends on fdtp_pkg, fdtp_front, fdtp_queue, fdtp_back
//
//  channel   direction  handshake          payload
//  input     in         push / full        word_i, first_i
//  result    out        empty / pop        event_kind_o, name_ref_o, data_offset_o,
//                                          data_length_o, bad_token_o
//  config    in         cfg_we_i           cfg_wdata_i (structure size in bytes)
//
// one word per cycle while full is low; a result request passes through the queue and then the output register
// words are classified combinationally by the front parser, results wait in a
// QueueDepth entry queue ahead of one output register
// full rises only when the queue is full, i.e. the result side has stalled
// asynchronous active-low reset, no clearing pass

module fdt_structure_token_parser_unit import fdtp_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] word_i,
  input  logic        first_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_kind_o,
  output logic [31:0] name_ref_o,
  output logic [31:0] data_offset_o,
  output logic [31:0] data_length_o,
  output logic [31:0] bad_token_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic accept;
  logic evt_valid;
  evt_t evt;
  logic q_valid, q_rd;
  evt_t q_data;

  assign accept = push && !full;

  fdtp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .word_i      (word_i),
    .first_i     (first_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  fdtp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (evt_valid),
    .wr_data_i (evt),
    .full_o    (full),
    .rd_i      (q_rd),
    .valid_o   (q_valid),
    .rd_data_o (q_data)
  );

  fdtp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_rd_o        (q_rd),
    .empty         (empty),
    .pop           (pop),
    .event_kind_o  (event_kind_o),
    .name_ref_o    (name_ref_o),
    .data_offset_o (data_offset_o),
    .data_length_o (data_length_o),
    .bad_token_o   (bad_token_o)
  );

endmodule

// ===== tb/fdt_structure_token_parser_unit_tb.sv =====
// fdt_structure_token_parser_unit_tb: self-checking bench for the structure block token parser
// directed table then random blobs, checked against table events or an in-bench parser model
// depends on fdtp_pkg and fdt_structure_token_parser_unit
`timescale 1ns / 1ps

module fdt_structure_token_parser_unit_tb;
  import fdtp_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    evt_kind_e   kind;
    logic [31:0] name_ref;
    logic [31:0] data_offset;
    logic [31:0] data_length;
    logic [31:0] bad_token;
  } fdt_event_t;

  typedef enum {ROW_WORD, ROW_SIZE} row_op_e;

  typedef struct {
    row_op_e     op;
    logic [31:0] wd;
    bit          first;
    bit          typed;
    bit          has_ev;
    fdt_event_t  ev;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] word_i = '0;
  logic        first_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  event_kind_o;
  logic [31:0] name_ref_o;
  logic [31:0] data_offset_o;
  logic [31:0] data_length_o;
  logic [31:0] bad_token_o;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  // parser model state
  logic [31:0] size_q = '0;
  phase_e      ph_q = PH_TOKEN;
  logic [31:0] pos_q = '0;
  logic [29:0] skip_q = '0;
  logic [31:0] plen_q = '0;
  bit          halt_q = 1'b0;

  fdt_event_t  pending_events[$];
  row_t        dir_rows[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          idle_on = 1'b1;

  fdt_structure_token_parser_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .word_i        (word_i),
    .first_i       (first_i),
    .empty         (empty),
    .pop           (pop),
    .event_kind_o  (event_kind_o),
    .name_ref_o    (name_ref_o),
    .data_offset_o (data_offset_o),
    .data_length_o (data_length_o),
    .bad_token_o   (bad_token_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("fdt_structure_token_parser_unit_tb: done, errors");
      $finish;
    end
  end

  // one structure word through the parser model; returns 1 when an event results
  function automatic bit parse_word(input logic [31:0] w, input bit f,
                                    output fdt_event_t ev);
    logic [31:0] cur;
    logic [31:0] rounded;
    bit          got;
    ev = '0;
    got = 1'b0;
    if (f) begin
      ph_q = PH_TOKEN;
      pos_q = '0;
      skip_q = '0;
      plen_q = '0;
      halt_q = 1'b0;
    end
    if (halt_q || pos_q >= size_q) return 1'b0;
    cur = pos_q;
    pos_q = (cur > PosLimit) ? 32'hFFFF_FFFF : cur + WordBytes;
    case (ph_q)
      PH_NAME: begin
        if (w[31:24] == 8'h0 || w[23:16] == 8'h0 || w[15:8] == 8'h0 || w[7:0] == 8'h0)
          ph_q = PH_TOKEN;
      end
      PH_PLEN: begin
        plen_q = w;
        ph_q = PH_PNAME;
      end
      PH_PNAME: begin
        ev.kind = EV_PROP;
        ev.name_ref = w;
        ev.data_offset = pos_q;
        ev.data_length = plen_q;
        got = 1'b1;
        rounded = plen_q + 32'd3;
        skip_q = rounded[31:2];
        ph_q = (skip_q == '0) ? PH_TOKEN : PH_SKIP;
      end
      PH_SKIP: begin
        skip_q = skip_q - 30'd1;
        if (skip_q == '0) ph_q = PH_TOKEN;
      end
      default: begin
        ph_q = PH_TOKEN;
        got = 1'b1;
        case (w)
          TokBeginNode: begin
            ev.kind = EV_BEGIN;
            ev.name_ref = pos_q;
            ph_q = PH_NAME;
          end
          TokEndNode: ev.kind = EV_ENDNODE;
          TokProp: begin
            ph_q = PH_PLEN;
            got = 1'b0;
          end
          TokNop: ev.kind = EV_NOP;
          TokEnd: ev.kind = EV_END;
          default: begin
            ev.kind = EV_BAD;
            ev.bad_token = w;
            halt_q = 1'b1;
          end
        endcase
      end
    endcase
    return got;
  endfunction

  // called at a falling edge, returns at a falling edge once the word is taken
  task automatic send_word(input logic [31:0] w, input bit f, input bit typed = 1'b0,
                           input bit has = 1'b0, input fdt_event_t tev = '0);
    fdt_event_t ev;
    bit         got;
    while (idle_on && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    word_i <= w;
    first_i <= f;
    do @(posedge clk_i); while (full);
    got = parse_word(w, f, ev);
    words_sent++;
    if (typed) begin
      if (has) pending_events.push_back(tev);
    end else if (got) begin
      pending_events.push_back(ev);
    end
    @(negedge clk_i);
  endtask

  // register write once the parser has drained
  task automatic set_size(input logic [31:0] v);
    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    size_q = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_name();
    int unsigned nw;
    logic [31:0] w;
    nw = $urandom_range(3, 1);
    repeat (nw - 1) begin
      w = {8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
           8'($urandom_range(255, 1)), 8'($urandom_range(255, 1))};
      send_word(w, 1'b0);
    end
    w = $urandom;
    w[8 * $urandom_range(3) +: 8] = 8'h0;
    send_word(w, 1'b0);
  endtask

  task automatic send_blob();
    int unsigned n_el;
    int unsigned pick;
    int unsigned r;
    logic [31:0] len;
    logic [31:0] rounded;
    send_word(TokBeginNode, 1'b1);
    send_name();
    n_el = $urandom_range(12, 1);
    repeat (n_el) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        r = $urandom_range(99);
        if (r < 70) len = $urandom_range(16);
        else if (r < 90) len = $urandom_range(64);
        else if (r < 95) len = 32'hFFFF_FFFD + $urandom_range(2);
        else len = $urandom_range(200);
        send_word(TokProp, 1'b0);
        send_word(len, 1'b0);
        send_word($urandom, 1'b0);
        rounded = len + 32'd3;
        repeat (rounded[31:2]) send_word($urandom, 1'b0);
      end else if (pick < 45) begin
        send_word(TokBeginNode, 1'b0);
        send_name();
      end else if (pick < 60) begin
        send_word(TokEndNode, 1'b0);
      end else if (pick < 72) begin
        send_word(TokNop, 1'b0);
      end else if (pick < 78) begin
        send_word(TokEnd, 1'b0);
      end else if (pick < 84) begin
        send_word($urandom, ($urandom_range(9) == 0));
      end else if (pick < 87) begin
        // broken property, any length
        send_word(TokProp, 1'b0);
        send_word($urandom, 1'b0);
      end else begin
        send_word(TokBeginNode, 1'b0);
        send_name();
        send_word(TokEndNode, 1'b0);
      end
    end
    send_word(TokEndNode, 1'b0);
    send_word(TokEnd, 1'b0);
  endtask

  task automatic add_row(input row_op_e op, input logic [31:0] wd, input bit f,
                         input bit typed, input bit has, input evt_kind_e k,
                         input logic [31:0] nr, input logic [31:0] od,
                         input logic [31:0] ln, input logic [31:0] bt);
    row_t r;
    r.op = op;
    r.wd = wd;
    r.first = f;
    r.typed = typed;
    r.has_ev = has;
    r.ev = '{kind: k, name_ref: nr, data_offset: od, data_length: ln, bad_token: bt};
    dir_rows.push_back(r);
  endtask

  // result side: bursty stalls while idle_on is set, about one cycle in eight
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(99) < 3) begin
      stall_left = $urandom_range(7);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    fdt_event_t exp_ev;
    if (rst_ni && pop && !empty) begin
      if (pending_events.size() == 0) begin
        $error("unexpected request: event_kind %0d", event_kind_o);
        mismatches++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (event_kind_o !== exp_ev.kind) begin
          $error("event_kind: expected %0d, got %0d", exp_ev.kind, event_kind_o);
          mismatches++;
        end
        if (name_ref_o !== exp_ev.name_ref) begin
          $error("name_ref: expected %h, got %h", exp_ev.name_ref, name_ref_o);
          mismatches++;
        end
        if (data_offset_o !== exp_ev.data_offset) begin
          $error("data_offset: expected %h, got %h", exp_ev.data_offset, data_offset_o);
          mismatches++;
        end
        if (data_length_o !== exp_ev.data_length) begin
          $error("data_length: expected %h, got %h", exp_ev.data_length, data_length_o);
          mismatches++;
        end
        if (bad_token_o !== exp_ev.bad_token) begin
          $error("bad_token: expected %h, got %h", exp_ev.bad_token, bad_token_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [31:0] sizes[7];
    int unsigned targets[7];
    int unsigned start_count;

    // size is zero out of reset, so the first word is ignored
    add_row(ROW_WORD, TokBeginNode,  1, 1, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_SIZE, 32'h0000_0100, 0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, TokBeginNode,  1, 1, 1, EV_BEGIN, 32'h4, 0, 0, 0);
    add_row(ROW_WORD, 32'h6162_6300, 0, 1, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, TokProp,       0, 1, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'h0000_0004, 0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'h0000_0010, 0, 1, 1, EV_PROP, 32'h10, 32'h14, 32'h4, 0);
    add_row(ROW_WORD, 32'hAAAA_5555, 0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, TokNop,        0, 1, 1, EV_NOP, 0, 0, 0, 0);
    add_row(ROW_WORD, TokEndNode,    0, 1, 1, EV_ENDNODE, 0, 0, 0, 0);
    add_row(ROW_WORD, TokEnd,        0, 1, 1, EV_END, 0, 0, 0, 0);
    // zero length property with the largest name offset
    add_row(ROW_WORD, TokProp,       0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'h0000_0000, 0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'hFFFF_FFFF, 0, 1, 1, EV_PROP, 32'hFFFF_FFFF, 32'h30, 0, 0);
    // length near the top wraps to no data words
    add_row(ROW_WORD, TokProp,       0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'hFFFF_FFFD, 0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'h0000_0000, 0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, TokBeginNode,  0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'hFFFF_FFFF, 0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'h01FF_0001, 0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'hDEAD_BEEF, 0, 1, 1, EV_BAD, 0, 0, 0, 32'hDEAD_BEEF);
    // halted until restart
    add_row(ROW_WORD, TokNop,        0, 1, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'hFFFF_FFFF, 1, 1, 1, EV_BAD, 0, 0, 0, 32'hFFFF_FFFF);
    // words past the structure end
    add_row(ROW_SIZE, 32'h0000_0006, 0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, TokBeginNode,  1, 1, 1, EV_BEGIN, 32'h4, 0, 0, 0);
    add_row(ROW_WORD, 32'h4142_4344, 0, 1, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, TokNop,        0, 1, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'h0000_0000, 1, 1, 1, EV_BAD, 0, 0, 0, 32'h0);
    // huge skip cut short by a restart
    add_row(ROW_SIZE, 32'hFFFF_FFFF, 0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, TokProp,       1, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'hFFFF_FFF0, 0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, 32'h0000_0007, 0, 0, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, TokNop,        0, 1, 0, EV_BEGIN, 0, 0, 0, 0);
    add_row(ROW_WORD, TokBeginNode,  1, 1, 1, EV_BEGIN, 32'h4, 0, 0, 0);

    sizes = '{32'hFFFF_FFFF, 32'h0000_0200, 32'($urandom_range(4096, 64)), 32'h0,
              32'h0000_0006, 32'($urandom_range(63, 1)), 32'hFFFF_FFFF};
    targets = '{220, 220, 180, 0, 60, 170, 180};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_SIZE) begin
        set_size(dir_rows[i].wd);
      end else begin
        send_word(dir_rows[i].wd, dir_rows[i].first, dir_rows[i].typed,
                  dir_rows[i].has_ev, dir_rows[i].ev);
      end
    end

    for (int p = 0; p < 7; p++) begin
      set_size(sizes[p]);
      idle_on = (p != 0);
      start_count = words_sent;
      do send_blob(); while (words_sent - start_count < targets[p]);
    end

    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("fdt_structure_token_parser_unit_tb: done, clean");
    end else begin
      $display("fdt_structure_token_parser_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== fdt_structure_token_parser_unit.f =====
hw/rtl/fdtp_pkg.sv
hw/rtl/fdtp_front.sv
hw/rtl/fdtp_queue.sv
hw/rtl/fdtp_back.sv
hw/rtl/fdt_structure_token_parser_unit.sv
tb/fdt_structure_token_parser_unit_tb.sv
